// ===== design/thd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thd_pkg: shared constants and types
// Field widths, counter sizing and the control bundles passed between the
// per-bit counter bank and the bit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
package thd_pkg;

   // set capacity and the bit positions that are counted
   localparam int MAX_ITEMS     = 16384;
   localparam int BIT_POSITIONS = 31;

   // item field widths
   localparam int WORD_W  = 31;
   localparam int TOTAL_W = 31;
   localparam int COUNT_W = 15;

   // counters hold 0 .. MAX_ITEMS
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   // accumulator: sum of BIT_POSITIONS products of two CNT_W values
   localparam int ACC_W = 2 * CNT_W + $clog2(BIT_POSITIONS + 1);

   // word widened to cover every counted position
   localparam int PAD_W = (BIT_POSITIONS > WORD_W) ? BIT_POSITIONS : WORD_W;

   // sequencer counter widths
   localparam int POS_W = (BIT_POSITIONS > 1) ? $clog2(BIT_POSITIONS) : 1;
   localparam int BIT_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;

   // width used to compare the word count against its output ceiling
   localparam int WIDE_W = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // counter bank controls
   typedef struct packed {
      logic count;   // add the current word
      logic drop;    // word ignored, set is full
      logic shift;   // move the bank down one position, zero fill at the top
      logic clear;   // end of set: clear word count and drop flag
   } cnt_ctl_type;

   // multiply-accumulate controls
   typedef struct packed {
      logic clear;   // zero the accumulator
      logic load;    // take a new pair of operands
      logic step;    // one multiplier bit
   } mac_ctl_type;

endpackage
`default_nettype wire

// ===== design/thd_bit_counters.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thd_bit_counters: per-bit ones counters
// One counter per bit position plus the word count and the drop flag. During
// the summing pass the bank works as a shift line that presents one position
// per step at its head and leaves zeros behind.
// ----------------------------------------------------------------------------
module thd_bit_counters (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [thd_pkg::WORD_W-1:0]    word,
   input  thd_pkg::cnt_ctl_type         ctl,
   output logic [thd_pkg::CNT_W-1:0]    ones_head,
   output logic [thd_pkg::CNT_W-1:0]    words_seen,
   output logic                         dropped,
   output logic                         full
);

   logic [thd_pkg::CNT_W-1:0] ones_ff [thd_pkg::BIT_POSITIONS];
   logic [thd_pkg::CNT_W-1:0] ones_in [thd_pkg::BIT_POSITIONS];
   logic [thd_pkg::CNT_W-1:0] words_ff, words_in;
   logic                      drop_ff, drop_in;
   logic [thd_pkg::PAD_W-1:0] word_pad;

   assign word_pad = thd_pkg::PAD_W'(word);

   // next counter values
   always_comb begin
      for (int b = 0; b < thd_pkg::BIT_POSITIONS; b++) begin
         ones_in[b] = ones_ff[b];
         if (ctl.count && word_pad[b]) begin
            ones_in[b] = ones_ff[b] + thd_pkg::CNT_W'(1);
         end
      end
      if (ctl.shift) begin
         for (int b = 0; b < thd_pkg::BIT_POSITIONS - 1; b++) begin
            ones_in[b] = ones_ff[b + 1];
         end
         ones_in[thd_pkg::BIT_POSITIONS - 1] = '0;
      end
   end

   // word count and drop flag
   always_comb begin
      words_in = words_ff;
      drop_in  = drop_ff;
      if (ctl.clear) begin
         words_in = '0;
         drop_in  = 1'b0;
      end else begin
         if (ctl.count) words_in = words_ff + thd_pkg::CNT_W'(1);
         if (ctl.drop)  drop_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < thd_pkg::BIT_POSITIONS; b++) begin
            ones_ff[b] <= '0;
         end
         words_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         ones_ff  <= ones_in;
         words_ff <= words_in;
         drop_ff  <= drop_in;
      end
   end

   assign ones_head  = ones_ff[0];
   assign words_seen = words_ff;
   assign dropped    = drop_ff;
   assign full       = (words_ff == thd_pkg::CNT_W'(thd_pkg::MAX_ITEMS));

endmodule
`default_nettype wire

// ===== design/thd_serial_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thd_serial_mac: bit-serial multiply-accumulate
// Forms ones * (words - ones) one multiplier bit per step with a shift-add
// and adds each product into a running total.
// ----------------------------------------------------------------------------
module thd_serial_mac (
   input  wire                          clock,
   input  wire                          reset,
   input  thd_pkg::mac_ctl_type         ctl,
   input  wire [thd_pkg::CNT_W-1:0]     ones,
   input  wire [thd_pkg::CNT_W-1:0]     words,
   output logic [thd_pkg::ACC_W-1:0]    acc
);

   logic [thd_pkg::ACC_W-1:0] md_ff;    // multiplicand, shifts left
   logic [thd_pkg::CNT_W-1:0] mr_ff;    // multiplier, shifts right
   logic [thd_pkg::ACC_W-1:0] acc_ff;
   logic [thd_pkg::CNT_W-1:0] zeros;

   assign zeros = words - ones;

   // operand shift registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         md_ff <= thd_pkg::ACC_W'(ones);
         mr_ff <= zeros;
      end else if (ctl.step) begin
         md_ff <= md_ff << 1;
         mr_ff <= mr_ff >> 1;
      end
   end

   // running total
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.step && mr_ff[0]) begin
         acc_ff <= acc_ff + md_ff;
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// ===== design/total_pairwise_hamming_distance_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// total_pairwise_hamming_distance_core: pairwise Hamming distance total
// Counts ones per bit position over a set of words; at the end of the set
// sums ones * (words - ones) over all positions and emits the total.
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: word; tlast: end of set
// rsp      out  rsp_tvalid/rsp_tready  tdata: total, count; tuser: overflow
//
// Words are taken one per cycle while a set loads. After the last word the
// summing pass runs, paced by the bit-serial multiplier that handles one
// multiplier bit per cycle, and then the result is loaded into the output
// register. req_tready is low during the pass.
// The result sits in an output register; a stalled rsp holds the next set's
// result back but not the loading of its words. Reset is synchronous.
// ----------------------------------------------------------------------------
module total_pairwise_hamming_distance_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [31:0]  req_tdata,    // [30:0] word, [31] zero
   input  wire          req_tlast,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [47:0]  rsp_tdata,    // [30:0] total_distance, [45:31] word_count,
                                      // [47:46] zero
   output logic [0:0]   rsp_tuser     // [0] overflow
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_OPND = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [thd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [thd_pkg::BIT_W-1:0]   bit_ff, bit_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [thd_pkg::TOTAL_W-1:0] total_ff;
   logic [thd_pkg::COUNT_W-1:0] count_ff;
   logic                        ovf_ff;

   thd_pkg::cnt_ctl_type        cnt_ctl;
   thd_pkg::mac_ctl_type        mac_ctl;
   logic [thd_pkg::CNT_W-1:0]   ones_head, words_seen;
   logic                        dropped, full;
   logic [thd_pkg::ACC_W-1:0]   acc;

   logic                        in_take, out_free, out_load;
   logic [thd_pkg::TOTAL_W-1:0] total_sat;
   logic [thd_pkg::COUNT_W-1:0] count_sat;
   logic [thd_pkg::WIDE_W-1:0]  words_wide;

   assign req_tready = (state_ff == ST_LOAD);
   assign in_take    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_OUT) && out_free;

   // counter bank and multiplier controls
   always_comb begin
      cnt_ctl.count = in_take && !full;
      cnt_ctl.drop  = in_take && full;
      cnt_ctl.shift = (state_ff == ST_OPND);
      cnt_ctl.clear = out_load;
      mac_ctl.clear = in_take && req_tlast;
      mac_ctl.load  = (state_ff == ST_OPND);
      mac_ctl.step  = (state_ff == ST_MUL);
   end

   thd_bit_counters u_counters (
      .clock      (clock),
      .reset      (reset),
      .word       (req_tdata[thd_pkg::WORD_W-1:0]),
      .ctl        (cnt_ctl),
      .ones_head  (ones_head),
      .words_seen (words_seen),
      .dropped    (dropped),
      .full       (full)
   );

   thd_serial_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .ones  (ones_head),
      .words (words_seen),
      .acc   (acc)
   );

   // sequencer: one position per operand load, CNT_W multiplier bits each
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      bit_in   = bit_ff;
      case (state_ff)
         ST_LOAD: begin
            if (in_take && req_tlast) begin
               state_in = ST_OPND;
               pos_in   = '0;
            end
         end
         ST_OPND: begin
            state_in = ST_MUL;
            bit_in   = '0;
         end
         ST_MUL: begin
            bit_in = bit_ff + thd_pkg::BIT_W'(1);
            if (bit_ff == thd_pkg::BIT_W'(thd_pkg::CNT_W - 1)) begin
               if (pos_ff == thd_pkg::POS_W'(thd_pkg::BIT_POSITIONS - 1)) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_OPND;
                  pos_in   = pos_ff + thd_pkg::POS_W'(1);
               end
            end
         end
         ST_OUT: begin
            if (out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         pos_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         bit_ff   <= bit_in;
      end
   end

   // saturate total and count to their field widths
   assign total_sat  = (acc > thd_pkg::ACC_W'(thd_pkg::TOTAL_MAX)) ?
                       thd_pkg::TOTAL_MAX : acc[thd_pkg::TOTAL_W-1:0];
   assign words_wide = thd_pkg::WIDE_W'(words_seen);
   assign count_sat  = (words_wide > thd_pkg::WIDE_W'(thd_pkg::COUNT_MAX)) ?
                       thd_pkg::COUNT_MAX : words_wide[thd_pkg::COUNT_W-1:0];

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         total_ff <= total_sat;
         count_ff <= count_sat;
         ovf_ff   <= dropped;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {2'b00, count_ff, total_ff};
   assign rsp_tuser[0] = ovf_ff;

endmodule
`default_nettype wire

// ===== design/thd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thd_checker: port-level checks
// Watches the top level's ports for output holding, end-of-set and overflow behavior.
// ----------------------------------------------------------------------------
module thd_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         req_tlast,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [47:0]  rsp_tdata,
   input wire [0:0]   rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // the end of a set starts the summing pass, no word is taken right after
   a_sum_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("word accepted right after end of set");

   // overflow only when the set reached capacity
   a_ovf_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
      rsp_tdata[45:31] == 15'(thd_pkg::MAX_ITEMS))
      else $error("overflow flagged below capacity");

endmodule

bind total_pairwise_hamming_distance_core thd_checker u_thd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
